FILE: rtl/atpd_pkg.sv
package atpd_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_DEADZONE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TENSION_TARGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_1    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_2    = 3'd7;

  // Register reset values
  localparam logic [14:0]        RST_AXIS_DEADZONE  = 15'd1638;
  localparam logic [15:0]        RST_STEP_GAIN      = 16'd154;
  localparam logic signed [15:0] RST_TENSION_TARGET = 16'sd30;
  localparam logic [15:0]        RST_KP_GAIN        = 16'd2560;
  localparam logic [15:0]        RST_KI_GAIN        = 16'd0;
  localparam logic [23:0]        RST_KD_GAIN        = 24'd640000;

  // Pull side codes, as driven on pull_side_o
  typedef enum logic [1:0] {
    PULL_NONE = 2'd0,
    PULL_M1   = 2'd1,
    PULL_M2   = 2'd2
  } pull_side_e;

endpackage

FILE: rtl/antagonistic_tendon_pid_drive_core.sv
// Antagonistic tendon pair drive: each item is one control tick (joystick axis, two
// tendon tensions, two motor positions) and yields one item with a position command
// per motor and the chosen pull side. The first tick after reset latches both
// positions as held targets. An axis beyond the deadzone picks a pull side; the
// pulling motor's held target moves by trunc(axis * step_gain / 2^23) and is
// commanded, while each slack motor gets its position plus a PID correction toward
// tension_target (integrals saturate at 32 bits). The datapath is a four-register
// pipeline: input register, error/integral stage, gain multiplier stage, and the
// output register. It takes one item per cycle unless the output stalls; each
// accepted item passes A, B, C and O in order. State (integrals, last tensions,
// held targets) changes in place, so back-to-back items see each other's effects.
// Each stage has its own ready, so bubbles fill up while the output waits.
// Write configuration only while the pipeline is empty; cfg_ready_o is always high.
module antagonistic_tendon_pid_drive_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [atpd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [atpd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [15:0]                  axis_i,
  input  logic signed [15:0]                  tension_1_i,
  input  logic signed [15:0]                  tension_2_i,
  input  logic signed [31:0]                  position_1_i,
  input  logic signed [31:0]                  position_2_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [31:0]                  command_1_o,
  output logic signed [31:0]                  command_2_o,
  output logic [1:0]                          pull_side_o
);

  import atpd_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [14:0]        axis_deadzone_q;
  logic [15:0]        step_gain_q;
  logic signed [15:0] tension_target_q;
  logic [15:0]        kp_gain_q;
  logic [15:0]        ki_gain_q;
  logic [23:0]        kd_gain_q;
  logic               direction_1_q;
  logic               direction_2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_deadzone_q  <= RST_AXIS_DEADZONE;
      step_gain_q      <= RST_STEP_GAIN;
      tension_target_q <= RST_TENSION_TARGET;
      kp_gain_q        <= RST_KP_GAIN;
      ki_gain_q        <= RST_KI_GAIN;
      kd_gain_q        <= RST_KD_GAIN;
      direction_1_q    <= 1'b0;
      direction_2_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_AXIS_DEADZONE:  axis_deadzone_q  <= cfg_data_i[14:0];
        REG_STEP_GAIN:      step_gain_q      <= cfg_data_i[15:0];
        REG_TENSION_TARGET: tension_target_q <= $signed(cfg_data_i[15:0]);
        REG_KP_GAIN:        kp_gain_q        <= cfg_data_i[15:0];
        REG_KI_GAIN:        ki_gain_q        <= cfg_data_i[15:0];
        REG_KD_GAIN:        kd_gain_q        <= cfg_data_i[23:0];
        REG_DIRECTION_1:    direction_1_q    <= cfg_data_i[0];
        REG_DIRECTION_2:    direction_2_q    <= cfg_data_i[0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: A (input) -> B (errors) -> C (products) -> O (output)
  // ---------------------------------------------------------------------------
  logic v_a_q, v_b_q, v_c_q, v_o_q;
  logic r_a, r_b, r_c, r_o;
  logic acc_in, adv_a, adv_b, adv_c;

  assign r_o    = !v_o_q || out_ready_i;
  assign adv_c  = v_c_q && r_o;
  assign r_c    = !v_c_q || r_o;
  assign adv_b  = v_b_q && r_c;
  assign r_b    = !v_b_q || r_c;
  assign adv_a  = v_a_q && r_b;
  assign r_a    = !v_a_q || r_b;
  assign acc_in = in_valid_i && r_a;

  assign in_ready_o  = r_a;
  assign out_valid_o = v_o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_o_q <= 1'b0;
    end else begin
      if (acc_in)          v_a_q <= 1'b1;
      else if (adv_a)      v_a_q <= 1'b0;
      if (adv_a)           v_b_q <= 1'b1;
      else if (adv_b)      v_b_q <= 1'b0;
      if (adv_b)           v_c_q <= 1'b1;
      else if (adv_c)      v_c_q <= 1'b0;
      if (adv_c)           v_o_q <= 1'b1;
      else if (out_ready_i) v_o_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: input register
  // ---------------------------------------------------------------------------
  logic signed [15:0] a_axis_q, a_t1_q, a_t2_q;
  logic signed [31:0] a_p1_q, a_p2_q;

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      a_axis_q <= axis_i;
      a_t1_q   <= tension_1_i;
      a_t2_q   <= tension_2_i;
      a_p1_q   <= position_1_i;
      a_p2_q   <= position_2_i;
    end
  end

  // Side pick, tension errors, derivative terms, saturating integrals, pull product.
  logic signed [16:0] axis_x, dz_x;
  pull_side_e         side_a;
  logic signed [16:0] err1, err2, der1, der2;
  logic signed [32:0] sum1_raw, sum2_raw;
  logic signed [31:0] sum1_sat, sum2_sat;
  logic signed [32:0] pull_prod;

  logic signed [31:0] err_sum_1_q, err_sum_2_q;
  logic signed [15:0] last_t1_q, last_t2_q;

  assign axis_x = {a_axis_q[15], a_axis_q};
  assign dz_x   = $signed({2'b00, axis_deadzone_q});

  always_comb begin
    side_a = PULL_NONE;
    if (axis_x > dz_x)  side_a = PULL_M1;
    if (axis_x < -dz_x) side_a = PULL_M2;
  end

  assign err1 = {tension_target_q[15], tension_target_q} - {a_t1_q[15], a_t1_q};
  assign err2 = {tension_target_q[15], tension_target_q} - {a_t2_q[15], a_t2_q};
  assign der1 = {a_t1_q[15], a_t1_q} - {last_t1_q[15], last_t1_q};
  assign der2 = {a_t2_q[15], a_t2_q} - {last_t2_q[15], last_t2_q};

  assign sum1_raw = {err_sum_1_q[31], err_sum_1_q} + {{16{err1[16]}}, err1};
  assign sum2_raw = {err_sum_2_q[31], err_sum_2_q} + {{16{err2[16]}}, err2};

  // Overflow shows as the two top bits differing; clamp toward the sign.
  always_comb begin
    sum1_sat = sum1_raw[31:0];
    if (sum1_raw[32] != sum1_raw[31]) sum1_sat = {sum1_raw[32], {31{!sum1_raw[32]}}};
    sum2_sat = sum2_raw[31:0];
    if (sum2_raw[32] != sum2_raw[31]) sum2_sat = {sum2_raw[32], {31{!sum2_raw[32]}}};
  end

  assign pull_prod = a_axis_q * $signed({1'b0, step_gain_q});

  // Integrals (but the pulling motor's) and last tensions advance as the item leaves stage A.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_sum_1_q <= '0;
      err_sum_2_q <= '0;
      last_t1_q   <= '0;
      last_t2_q   <= '0;
    end else if (adv_a) begin
      if (side_a != PULL_M1) err_sum_1_q <= sum1_sat;
      if (side_a != PULL_M2) err_sum_2_q <= sum2_sat;
      last_t1_q <= a_t1_q;
      last_t2_q <= a_t2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B register
  // ---------------------------------------------------------------------------
  pull_side_e         b_side_q;
  logic signed [16:0] b_err1_q, b_err2_q, b_der1_q, b_der2_q;
  logic signed [31:0] b_sum1_q, b_sum2_q;
  logic signed [32:0] b_prod_q;
  logic signed [31:0] b_p1_q, b_p2_q;

  always_ff @(posedge clk_i) begin
    if (adv_a) begin
      b_side_q <= side_a;
      b_err1_q <= err1;
      b_err2_q <= err2;
      b_der1_q <= der1;
      b_der2_q <= der2;
      b_sum1_q <= sum1_sat;
      b_sum2_q <= sum2_sat;
      b_prod_q <= pull_prod;
      b_p1_q   <= a_p1_q;
      b_p2_q   <= a_p2_q;
    end
  end

  // Gain products; held target update from the pull step.
  logic signed [33:0] pterm1, pterm2;
  logic signed [48:0] iterm1, iterm2;
  logic signed [41:0] dterm1, dterm2;
  logic               step_rnd;
  logic signed [9:0]  step_w;
  logic signed [31:0] step32, step1, step2;
  logic signed [31:0] base1, base2, hold1_d, hold2_d;
  logic signed [31:0] held_1_q, held_2_q;
  logic               loaded_q;

  assign pterm1 = $signed({1'b0, kp_gain_q}) * b_err1_q;
  assign pterm2 = $signed({1'b0, kp_gain_q}) * b_err2_q;
  assign iterm1 = $signed({1'b0, ki_gain_q}) * b_sum1_q;
  assign iterm2 = $signed({1'b0, ki_gain_q}) * b_sum2_q;
  assign dterm1 = $signed({1'b0, kd_gain_q}) * b_der1_q;
  assign dterm2 = $signed({1'b0, kd_gain_q}) * b_der2_q;

  // Divide by 2^23 rounding toward zero: floor shift, plus one if negative and inexact.
  assign step_rnd = b_prod_q[32] && (b_prod_q[22:0] != '0);
  assign step_w   = $signed(b_prod_q[32:23]) + $signed({9'd0, step_rnd});
  assign step32   = {{22{step_w[9]}}, step_w};
  assign step1    = direction_1_q ? -step32 : step32;
  assign step2    = direction_2_q ? -step32 : step32;

  assign base1   = loaded_q ? held_1_q : b_p1_q;
  assign base2   = loaded_q ? held_2_q : b_p2_q;
  assign hold1_d = (b_side_q == PULL_M1) ? base1 + step1 : base1;
  assign hold2_d = (b_side_q == PULL_M2) ? base2 + step2 : base2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_1_q <= '0;
      held_2_q <= '0;
      loaded_q <= 1'b0;
    end else if (adv_b) begin
      held_1_q <= hold1_d;
      held_2_q <= hold2_d;
      loaded_q <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C register
  // ---------------------------------------------------------------------------
  pull_side_e         c_side_q;
  logic signed [33:0] c_pt1_q, c_pt2_q;
  logic signed [48:0] c_it1_q, c_it2_q;
  logic signed [41:0] c_dt1_q, c_dt2_q;
  logic signed [31:0] c_hold1_q, c_hold2_q;
  logic signed [31:0] c_p1_q, c_p2_q;

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      c_side_q  <= b_side_q;
      c_pt1_q   <= pterm1;
      c_pt2_q   <= pterm2;
      c_it1_q   <= iterm1;
      c_it2_q   <= iterm2;
      c_dt1_q   <= dterm1;
      c_dt2_q   <= dterm2;
      c_hold1_q <= hold1_d;
      c_hold2_q <= hold2_d;
      c_p1_q    <= b_p1_q;
      c_p2_q    <= b_p2_q;
    end
  end

  // PID sum in Q.8, truncated toward zero, signed by direction, added to position.
  logic signed [49:0] acc1, acc2;
  logic               rnd1, rnd2;
  logic signed [31:0] dlt1, dlt2, pid1, pid2, cmd1_d, cmd2_d;

  assign acc1 = {{16{c_pt1_q[33]}}, c_pt1_q} + {c_it1_q[48], c_it1_q}
              - {{8{c_dt1_q[41]}}, c_dt1_q};
  assign acc2 = {{16{c_pt2_q[33]}}, c_pt2_q} + {c_it2_q[48], c_it2_q}
              - {{8{c_dt2_q[41]}}, c_dt2_q};

  assign rnd1 = acc1[49] && (acc1[7:0] != '0);
  assign rnd2 = acc2[49] && (acc2[7:0] != '0);
  assign dlt1 = acc1[39:8] + {31'd0, rnd1};
  assign dlt2 = acc2[39:8] + {31'd0, rnd2};
  assign pid1 = c_p1_q + (direction_1_q ? -dlt1 : dlt1);
  assign pid2 = c_p2_q + (direction_2_q ? -dlt2 : dlt2);

  assign cmd1_d = (c_side_q == PULL_M1) ? c_hold1_q : pid1;
  assign cmd2_d = (c_side_q == PULL_M2) ? c_hold2_q : pid2;

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic signed [31:0] o_cmd1_q, o_cmd2_q;
  pull_side_e         o_side_q;

  always_ff @(posedge clk_i) begin
    if (adv_c) begin
      o_cmd1_q <= cmd1_d;
      o_cmd2_q <= cmd2_d;
      o_side_q <= c_side_q;
    end
  end

  assign command_1_o = o_cmd1_q;
  assign command_2_o = o_cmd2_q;
  assign pull_side_o = o_side_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_loaded_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q |=> loaded_q)
    else $error("held targets lost their loaded flag");

  a_pull1_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_a && side_a == PULL_M1) |=> $stable(err_sum_1_q))
    else $error("motor 1 integral changed while motor 1 pulls");

  a_pull2_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_a && side_a == PULL_M2) |=> $stable(err_sum_2_q))
    else $error("motor 2 integral changed while motor 2 pulls");

  a_pid_state_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_a |=> ($stable(err_sum_1_q) && $stable(err_sum_2_q)
                && $stable(last_t1_q) && $stable(last_t2_q)))
    else $error("PID state moved without an item leaving the input stage");

  a_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_b |=> ($stable(held_1_q) && $stable(held_2_q)))
    else $error("held targets moved without an item leaving the error stage");

endmodule
